[design/cbc_pkg.sv]
// ----------------------------------------------------------------------------
// cbc_pkg: shared types and constants for the circle/box collision block
// Field widths that do not vary and the facing-direction code.
// ----------------------------------------------------------------------------
package cbc_pkg;

  // Width of the diameter and box size fields, and of the overlap results
  localparam int DIM_BITS = 16;

  // Facing direction of the closest box point as seen from the ball centre
  typedef enum logic [2:0] {
    DIR_UP    = 3'd0,
    DIR_RIGHT = 3'd1,
    DIR_DOWN  = 3'd2,
    DIR_LEFT  = 3'd3,
    DIR_NONE  = 3'd4
  } dir_t;

  typedef logic [DIM_BITS-1:0] dim_t;

endpackage

[design/circle_box_collision_top.sv]
// ----------------------------------------------------------------------------
// circle_box_collision_top: circle versus axis-aligned box hit test
// Tests one ball/box pair per transaction and reports the hit flags, the
// facing direction and the per-axis penetration depth.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_*): ball square corner and diameter plus box corner
//   and size, 1/16 pixel units. A transaction completes on a rising edge
//   with in_valid high and in_stall low.
//   Result channel (out_*): one result per input transaction, in order,
//   overlaps in 1/32 pixel units. Taken on an edge with out_valid high and
//   out_stall low.
//   Flow: a transaction passes the input register, then the result
//   register. One transaction per cycle sustained while out_stall stays
//   low; the whole test (clamp, three squares, compare) sits between the
//   input register and the result register.
//   Stall: while the result register is held and the input register is
//   full, in_stall goes high in the same cycle; an empty input register
//   still accepts one transaction.
//   Reset: rst_n low clears both valid flags; no transaction is in flight
//   afterwards.
// ----------------------------------------------------------------------------
module circle_box_collision_top #(
  parameter int COORD_BITS = 20
) (
  input  logic                           clk,
  input  logic                           rst_n,
  // input channel
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic signed [COORD_BITS-1:0]   in_ball_x,
  input  logic signed [COORD_BITS-1:0]   in_ball_y,
  input  cbc_pkg::dim_t                  in_ball_diameter,
  input  logic signed [COORD_BITS-1:0]   in_box_x,
  input  logic signed [COORD_BITS-1:0]   in_box_y,
  input  cbc_pkg::dim_t                  in_box_width,
  input  cbc_pkg::dim_t                  in_box_height,
  // result channel
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic                           out_hit_inclusive,
  output logic                           out_hit_strict,
  output logic [2:0]                     out_direction,
  output cbc_pkg::dim_t                  out_overlap_x,
  output cbc_pkg::dim_t                  out_overlap_y
);
  import cbc_pkg::*;

  // Working width of centre differences and clamp offsets
  localparam int WIDE_BITS = (COORD_BITS + 1 > DIM_BITS + 1) ? COORD_BITS + 1 : DIM_BITS + 1;
  localparam int DW        = WIDE_BITS + 2;
  localparam int SQ_BITS   = 2 * DIM_BITS;

  // Input register
  logic                          s1_vld_r;
  logic signed [COORD_BITS-1:0]  ball_x_r, ball_y_r, box_x_r, box_y_r;
  dim_t                          diam_r, width_r, height_r;

  // Result register
  logic                          out_vld_r;
  logic                          hit_incl_r, hit_strict_r;
  dir_t                          dir_r;
  dim_t                          ovx_r, ovy_r;

  logic advance_out, advance_in;

  // Datapath signals
  logic signed [DW-1:0] bx_e, by_e, kx_e, ky_e;
  logic signed [DW-1:0] r_e, hw_e, hh_e;
  logic signed [DW-1:0] diff_x, diff_y, dx, dy;
  logic        [DW-1:0] ax_w, ay_w;
  dim_t                 ax, ay;
  logic                 near;
  logic [SQ_BITS-1:0]   ax2, ay2, r2;
  logic [SQ_BITS:0]     len2;
  logic                 incl_nxt, strict_nxt;
  logic                 x_pos, x_neg, y_pos, y_neg, x_nz, y_nz;
  dir_t                 dir_x, dir_y, dir_nxt;
  dim_t                 ovx_nxt, ovy_nxt;

  // Pipeline flow: the result register frees when empty or taken
  assign advance_out = !out_vld_r || !out_stall;
  assign advance_in  = !s1_vld_r || advance_out;
  assign in_stall    = !advance_in;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      if (advance_in) begin
        s1_vld_r <= in_valid;
      end
      if (advance_out) begin
        out_vld_r <= s1_vld_r;
      end
    end
  end

  // Capture an accepted transaction
  always_ff @(posedge clk) begin
    if (in_valid && advance_in) begin
      ball_x_r <= in_ball_x;
      ball_y_r <= in_ball_y;
      diam_r   <= in_ball_diameter;
      box_x_r  <= in_box_x;
      box_y_r  <= in_box_y;
      width_r  <= in_box_width;
      height_r <= in_box_height;
    end
  end

  // Extend to the working width; lengths hold one extra fraction bit,
  // so the radius is the diameter and each half-extent is the full size
  always_comb begin
    bx_e = {{(DW-COORD_BITS){ball_x_r[COORD_BITS-1]}}, ball_x_r};
    by_e = {{(DW-COORD_BITS){ball_y_r[COORD_BITS-1]}}, ball_y_r};
    kx_e = {{(DW-COORD_BITS){box_x_r[COORD_BITS-1]}}, box_x_r};
    ky_e = {{(DW-COORD_BITS){box_y_r[COORD_BITS-1]}}, box_y_r};
    r_e  = {{(DW-DIM_BITS){1'b0}}, diam_r};
    hw_e = {{(DW-DIM_BITS){1'b0}}, width_r};
    hh_e = {{(DW-DIM_BITS){1'b0}}, height_r};

    // Centre differences in doubled units
    diff_x = ((bx_e <<< 1) + r_e) - ((kx_e <<< 1) + hw_e);
    diff_y = ((by_e <<< 1) + r_e) - ((ky_e <<< 1) + hh_e);

    // Offset from the centre to the closest box point
    if (diff_x > hw_e) begin
      dx = hw_e - diff_x;
    end else if (diff_x < -hw_e) begin
      dx = -hw_e - diff_x;
    end else begin
      dx = '0;
    end
    if (diff_y > hh_e) begin
      dy = hh_e - diff_y;
    end else if (diff_y < -hh_e) begin
      dy = -hh_e - diff_y;
    end else begin
      dy = '0;
    end

    ax_w = dx[DW-1] ? DW'(-dx) : DW'(dx);
    ay_w = dy[DW-1] ? DW'(-dy) : DW'(dy);
    near = (ax_w <= DW'(diam_r)) && (ay_w <= DW'(diam_r));
    ax   = ax_w[DIM_BITS-1:0];
    ay   = ay_w[DIM_BITS-1:0];

    // Squared length against squared radius
    ax2  = SQ_BITS'(ax) * SQ_BITS'(ax);
    ay2  = SQ_BITS'(ay) * SQ_BITS'(ay);
    r2   = SQ_BITS'(diam_r) * SQ_BITS'(diam_r);
    len2 = {1'b0, ax2} + {1'b0, ay2};
    incl_nxt   = near && (len2 <= {1'b0, r2});
    strict_nxt = near && (len2 <  {1'b0, r2});

    // Facing direction: larger axis wins, ties go to the earlier code
    x_neg = dx[DW-1];
    y_neg = dy[DW-1];
    x_nz  = (dx != '0);
    y_nz  = (dy != '0);
    x_pos = x_nz && !x_neg;
    y_pos = y_nz && !y_neg;
    dir_x = x_pos ? DIR_RIGHT : DIR_LEFT;
    dir_y = y_pos ? DIR_UP : DIR_DOWN;
    if (!incl_nxt || (!x_nz && !y_nz)) begin
      dir_nxt = DIR_NONE;
    end else if (!x_nz) begin
      dir_nxt = dir_y;
    end else if (!y_nz) begin
      dir_nxt = dir_x;
    end else if (ay > ax) begin
      dir_nxt = dir_y;
    end else if (ax > ay) begin
      dir_nxt = dir_x;
    end else begin
      dir_nxt = (dir_y < dir_x) ? dir_y : dir_x;
    end

    // Penetration depth per axis, zero on a miss
    ovx_nxt = incl_nxt ? dim_t'(diam_r - ax) : '0;
    ovy_nxt = incl_nxt ? dim_t'(diam_r - ay) : '0;
  end

  // Result register
  always_ff @(posedge clk) begin
    if (advance_out) begin
      hit_incl_r   <= incl_nxt;
      hit_strict_r <= strict_nxt;
      dir_r        <= dir_nxt;
      ovx_r        <= ovx_nxt;
      ovy_r        <= ovy_nxt;
    end
  end

  assign out_valid         = out_vld_r;
  assign out_hit_inclusive = hit_incl_r;
  assign out_hit_strict    = hit_strict_r;
  assign out_direction     = dir_r;
  assign out_overlap_x     = ovx_r;
  assign out_overlap_y     = ovy_r;

`ifndef SYNTHESIS
  // A strict hit is always an inclusive hit
  a_strict_in_incl: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && hit_strict_r |-> hit_incl_r)
    else $error("strict hit without inclusive hit");

  // A miss carries no direction and no penetration
  a_miss_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && !hit_incl_r |-> dir_r == DIR_NONE && ovx_r == '0 && ovy_r == '0)
    else $error("miss with direction or overlap");

  // Centre inside the box: both overlaps equal the radius
  a_inside_equal: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && hit_incl_r && dir_r == DIR_NONE |-> ovx_r == ovy_r)
    else $error("inside hit with unequal overlaps");

  // Input side stalls only with both registers full
  a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> s1_vld_r && out_vld_r && out_stall)
    else $error("input stalled with room in the pipeline");

  // A held result keeps its payload
  a_hold_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && out_stall |=> out_vld_r && $stable(dir_r) && $stable(ovx_r))
    else $error("held result changed");
`endif

endmodule
